// ===== rtl/hsv_to_rgb_convert_macros.svh =====
// Assertion macros for the conversion block checkers.
// Each macro expects a signal named clock, and the reset-gated ones one named reset, in the scope where it is used.
`ifndef HSV_TO_RGB_CONVERT_MACROS_SVH
`define HSV_TO_RGB_CONVERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high
`define HSVRGB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hsv_to_rgb_convert: assertion failed");

// Next-cycle implication, ignored while reset is high
`define HSVRGB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hsv_to_rgb_convert: assertion failed");

// Next-cycle implication, checked during reset as well
`define HSVRGB_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("hsv_to_rgb_convert: assertion failed");

`endif

// ===== rtl/hsvrgb_pkg.sv =====
`default_nettype none

package hsvrgb_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CHANNEL_BITS = 8;
   localparam int LEVEL_BITS   = FRAC_BITS + 1;
   localparam int SECTOR_BITS  = 3;

   localparam logic [LEVEL_BITS-1:0]   ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CHANNEL_BITS-1:0] CH_MAX = {CHANNEL_BITS{1'b1}};

   // Hue sectors, sixty degrees each
   localparam logic [SECTOR_BITS-1:0] SEC_RED     = 3'd0;
   localparam logic [SECTOR_BITS-1:0] SEC_YELLOW  = 3'd1;
   localparam logic [SECTOR_BITS-1:0] SEC_GREEN   = 3'd2;
   localparam logic [SECTOR_BITS-1:0] SEC_CYAN    = 3'd3;
   localparam logic [SECTOR_BITS-1:0] SEC_BLUE    = 3'd4;
   localparam logic [SECTOR_BITS-1:0] SEC_MAGENTA = 3'd5;

   typedef struct packed {
      logic [FRAC_BITS-1:0]  hue;
      logic [LEVEL_BITS-1:0] saturation;
      logic [LEVEL_BITS-1:0] brightness;
   } req_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/hsvrgb_to_channel.sv =====
`default_nettype none

module hsvrgb_to_channel
   import hsvrgb_pkg::*;
(
   input  wire logic [LEVEL_BITS-1:0]   level,
   output logic      [CHANNEL_BITS-1:0] chan
);

   localparam int PROD_BITS = LEVEL_BITS + CHANNEL_BITS;

   logic [PROD_BITS-1:0] prod;

   // A level of exactly one lands on the top code, so no clamp is needed
   assign prod = PROD_BITS'(level) * PROD_BITS'(CH_MAX);
   assign chan = prod[FRAC_BITS +: CHANNEL_BITS];

endmodule

`default_nettype wire

// ===== rtl/hsv_to_rgb_convert.sv =====
`default_nettype none

// HSV to RGB pixel converter. One pixel beat enters per clock while req_stall is
// low; its RGB beat passes through a four-stage pipeline to the rsp port: clamp and
// hue times six, the saturation products and p, the q and t products, then sector
// selection and scaling to channel codes into the output register. Throughput is
// one pixel per clock while rsp_stall is low, set by the fully pipelined
// multipliers; rsp_stall holds the pipeline, empty stages still fill while stalled,
// and req_stall rises only once every stage is occupied. Hue wraps on whole turns;
// saturation and value above 1.0 clamp to 1.0.
module hsv_to_rgb_convert
   import hsvrgb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int SCALED_BITS = FRAC_BITS + SECTOR_BITS;
   localparam int PROD_BITS   = 2 * LEVEL_BITS;

   logic rdy1, rdy2, rdy3, rdy4;

   // stage 1: clamp, hue times six
   logic [SCALED_BITS-1:0] scaled;
   logic [SECTOR_BITS-1:0] s1_sector_in, s1_sector_ff;
   logic [FRAC_BITS-1:0]   s1_frac_in, s1_frac_ff;
   logic [LEVEL_BITS-1:0]  s1_sat_in, s1_sat_ff;
   logic [LEVEL_BITS-1:0]  s1_val_in, s1_val_ff;
   logic                   s1_valid_ff;

   // stage 2: s*f, s*(1-f), p
   logic [LEVEL_BITS-1:0]  one_minus_f, one_minus_s;
   logic [PROD_BITS-1:0]   sf_prod, sf1_prod, p_prod;
   logic [SECTOR_BITS-1:0] s2_sector_ff;
   logic [LEVEL_BITS-1:0]  s2_val_ff;
   logic [LEVEL_BITS-1:0]  s2_sf_in, s2_sf_ff;
   logic [LEVEL_BITS-1:0]  s2_sf1_in, s2_sf1_ff;
   logic [LEVEL_BITS-1:0]  s2_p_in, s2_p_ff;
   logic                   s2_valid_ff;

   // stage 3: q, t
   logic [PROD_BITS-1:0]   q_prod, t_prod;
   logic [SECTOR_BITS-1:0] s3_sector_ff;
   logic [LEVEL_BITS-1:0]  s3_val_ff;
   logic [LEVEL_BITS-1:0]  s3_p_ff;
   logic [LEVEL_BITS-1:0]  s3_q_in, s3_q_ff;
   logic [LEVEL_BITS-1:0]  s3_t_in, s3_t_ff;
   logic                   s3_valid_ff;

   // stage 4: sector select, channel scaling
   logic [LEVEL_BITS-1:0]  lvl_r, lvl_g, lvl_b;
   rsp_type                s4_data_in, s4_data_ff;
   logic                   s4_valid_ff;

   // A stage takes a new beat when it is empty or its contents move on
   assign rdy4      = !s4_valid_ff || !rsp_stall;
   assign rdy3      = !s3_valid_ff || rdy4;
   assign rdy2      = !s2_valid_ff || rdy3;
   assign rdy1      = !s1_valid_ff || rdy2;
   assign req_stall = !rdy1;

   assign scaled       = (SCALED_BITS'(req_data.hue) << 2) + (SCALED_BITS'(req_data.hue) << 1);
   assign s1_sector_in = scaled[FRAC_BITS +: SECTOR_BITS];
   assign s1_frac_in   = scaled[FRAC_BITS-1:0];
   assign s1_sat_in    = (req_data.saturation > ONE_FX) ? ONE_FX : req_data.saturation;
   assign s1_val_in    = (req_data.brightness > ONE_FX) ? ONE_FX : req_data.brightness;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rdy1) begin
         s1_valid_ff <= req_valid;
      end
      if (rdy1) begin
         s1_sector_ff <= s1_sector_in;
         s1_frac_ff   <= s1_frac_in;
         s1_sat_ff    <= s1_sat_in;
         s1_val_ff    <= s1_val_in;
      end
   end

   // Zero saturation needs no special path: p, q and t all come out equal to v
   assign one_minus_f = ONE_FX - LEVEL_BITS'(s1_frac_ff);
   assign one_minus_s = ONE_FX - s1_sat_ff;
   assign sf_prod     = PROD_BITS'(s1_sat_ff) * PROD_BITS'(s1_frac_ff);
   assign sf1_prod    = PROD_BITS'(s1_sat_ff) * PROD_BITS'(one_minus_f);
   assign p_prod      = PROD_BITS'(s1_val_ff) * PROD_BITS'(one_minus_s);
   assign s2_sf_in    = sf_prod[FRAC_BITS +: LEVEL_BITS];
   assign s2_sf1_in   = sf1_prod[FRAC_BITS +: LEVEL_BITS];
   assign s2_p_in     = p_prod[FRAC_BITS +: LEVEL_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (rdy2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (rdy2) begin
         s2_sector_ff <= s1_sector_ff;
         s2_val_ff    <= s1_val_ff;
         s2_sf_ff     <= s2_sf_in;
         s2_sf1_ff    <= s2_sf1_in;
         s2_p_ff      <= s2_p_in;
      end
   end

   assign q_prod  = PROD_BITS'(s2_val_ff) * PROD_BITS'(ONE_FX - s2_sf_ff);
   assign t_prod  = PROD_BITS'(s2_val_ff) * PROD_BITS'(ONE_FX - s2_sf1_ff);
   assign s3_q_in = q_prod[FRAC_BITS +: LEVEL_BITS];
   assign s3_t_in = t_prod[FRAC_BITS +: LEVEL_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (rdy3) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (rdy3) begin
         s3_sector_ff <= s2_sector_ff;
         s3_val_ff    <= s2_val_ff;
         s3_p_ff      <= s2_p_ff;
         s3_q_ff      <= s3_q_in;
         s3_t_ff      <= s3_t_in;
      end
   end

   always_comb begin
      case (s3_sector_ff)
         SEC_RED: begin
            lvl_r = s3_val_ff; lvl_g = s3_t_ff;   lvl_b = s3_p_ff;
         end
         SEC_YELLOW: begin
            lvl_r = s3_q_ff;   lvl_g = s3_val_ff; lvl_b = s3_p_ff;
         end
         SEC_GREEN: begin
            lvl_r = s3_p_ff;   lvl_g = s3_val_ff; lvl_b = s3_t_ff;
         end
         SEC_CYAN: begin
            lvl_r = s3_p_ff;   lvl_g = s3_q_ff;   lvl_b = s3_val_ff;
         end
         SEC_BLUE: begin
            lvl_r = s3_t_ff;   lvl_g = s3_p_ff;   lvl_b = s3_val_ff;
         end
         default: begin
            lvl_r = s3_val_ff; lvl_g = s3_p_ff;   lvl_b = s3_q_ff;
         end
      endcase
   end

   hsvrgb_to_channel u_chan_r (.level(lvl_r), .chan(s4_data_in.red));
   hsvrgb_to_channel u_chan_g (.level(lvl_g), .chan(s4_data_in.green));
   hsvrgb_to_channel u_chan_b (.level(lvl_b), .chan(s4_data_in.blue));

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (rdy4) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (rdy4) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign rsp_valid = s4_valid_ff;
   assign rsp_data  = s4_data_ff;

endmodule

`default_nettype wire

// ===== rtl/hsvrgb_checker.sv =====
`default_nettype none

`include "hsv_to_rgb_convert_macros.svh"

module hsvrgb_checker
   import hsvrgb_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A stalled request beat holds
   `HSVRGB_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_data))

   // A stalled result beat holds
   `HSVRGB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Reset empties the pipeline
   `HSVRGB_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)

   // With the output draining, the pipeline never pushes back
   `HSVRGB_ASSERT_NOW(a_flow_through, !rsp_stall, !req_stall)

   // An accepted beat reaches the output when the output does not stall meanwhile
   `HSVRGB_ASSERT_NEXT(a_latency,
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall, rsp_valid)

endmodule

bind hsv_to_rgb_convert hsvrgb_checker u_hsvrgb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== dv/tb_hsv_to_rgb_convert.sv =====
`timescale 1ns / 100ps

module tb_hsv_to_rgb_convert;
   import hsvrgb_pkg::*;

   localparam int DIRECTED_LEVELS = 6;
   localparam int RANDOM_PIXELS   = 1550;
   localparam int STEADY_FIRST    = 800;
   localparam int STEADY_LAST     = 1100;
   localparam int IDLE_PERCENT    = 15;
   localparam int DRAIN_CYCLES    = 20;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pixel_pending_q[$];
   rsp_type rgb_expect_q[$];
   logic    req_fire       = 1'b0;
   int      beats_sent     = 0;
   int      mismatch_count = 0;

   hsv_to_rgb_convert dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Product of two Q1.16 levels, truncated back to Q1.16
   function automatic logic [39:0] q16_product(input logic [39:0] a, input logic [39:0] b);
      return (a * b) >> FRAC_BITS;
   endfunction

   function automatic logic [CHANNEL_BITS-1:0] level_to_code(input logic [39:0] level);
      logic [39:0] scaled;
      scaled = (level * 40'(CH_MAX)) >> FRAC_BITS;
      return scaled[CHANNEL_BITS-1:0];
   endfunction

   function automatic rsp_type predict_rgb(input req_type px);
      logic [39:0]            sat, val, hue6, frac, p_lvl, q_lvl, t_lvl;
      logic [39:0]            r_lvl, g_lvl, b_lvl;
      logic [SECTOR_BITS-1:0] sector;
      rsp_type                rgb;
      sat   = (px.saturation > ONE_FX) ? 40'(ONE_FX) : 40'(px.saturation);
      val   = (px.brightness > ONE_FX) ? 40'(ONE_FX) : 40'(px.brightness);
      r_lvl = val;
      g_lvl = val;
      b_lvl = val;
      if (sat != 0) begin
         hue6   = 40'(px.hue) * 40'd6;
         sector = hue6[FRAC_BITS +: SECTOR_BITS];
         frac   = hue6 & ((40'd1 << FRAC_BITS) - 1);
         p_lvl  = q16_product(val, 40'(ONE_FX) - sat);
         q_lvl  = q16_product(val, 40'(ONE_FX) - q16_product(sat, frac));
         t_lvl  = q16_product(val, 40'(ONE_FX) - q16_product(sat, 40'(ONE_FX) - frac));
         case (sector)
            SEC_RED: begin
               r_lvl = val;   g_lvl = t_lvl; b_lvl = p_lvl;
            end
            SEC_YELLOW: begin
               r_lvl = q_lvl; g_lvl = val;   b_lvl = p_lvl;
            end
            SEC_GREEN: begin
               r_lvl = p_lvl; g_lvl = val;   b_lvl = t_lvl;
            end
            SEC_CYAN: begin
               r_lvl = p_lvl; g_lvl = q_lvl; b_lvl = val;
            end
            SEC_BLUE: begin
               r_lvl = t_lvl; g_lvl = p_lvl; b_lvl = val;
            end
            default: begin
               // magenta
               r_lvl = val;   g_lvl = p_lvl; b_lvl = q_lvl;
            end
         endcase
      end
      rgb.red   = level_to_code(r_lvl);
      rgb.green = level_to_code(g_lvl);
      rgb.blue  = level_to_code(b_lvl);
      return rgb;
   endfunction

   function automatic logic [LEVEL_BITS-1:0] random_level();
      case ($urandom_range(5))
         0:       return '0;
         1:       return ONE_FX;
         2:       return LEVEL_BITS'($urandom_range(131071));
         3:       return LEVEL_BITS'($urandom_range(131071, 65535));
         default: return LEVEL_BITS'($urandom_range(65536));
      endcase
   endfunction

   function automatic logic [FRAC_BITS-1:0] random_hue();
      int edge_hue;
      if ($urandom_range(9) == 0) begin
         // land next to a sector boundary
         edge_hue = ($urandom_range(5) * 65536 + 5) / 6 + $urandom_range(4) - 2;
         return FRAC_BITS'(edge_hue);
      end
      return FRAC_BITS'($urandom_range(65535));
   endfunction

   task automatic queue_pixel(input logic [FRAC_BITS-1:0] hue,
                              input logic [LEVEL_BITS-1:0] sat,
                              input logic [LEVEL_BITS-1:0] val);
      req_type px;
      px.hue        = hue;
      px.saturation = sat;
      px.brightness = val;
      pixel_pending_q.push_back(px);
   endtask

   // Wait until every queued beat has gone in and every result has come out
   task automatic drain_pipeline();
      while (pixel_pending_q.size() != 0 || req_valid) @(posedge clock);
      while (rgb_expect_q.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic steady_window();
      return beats_sent >= STEADY_FIRST && beats_sent < STEADY_LAST;
   endfunction

   // Driver: offer a new beat once the previous one has been taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pixel_pending_q.size() != 0 &&
             (steady_window() || $urandom_range(99) >= IDLE_PERCENT)) begin
            req_data   <= pixel_pending_q.pop_front();
            req_valid  <= 1'b1;
            beats_sent <= beats_sent + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !steady_window() && $urandom_range(99) < IDLE_PERCENT;
      end
   end

   // Record accepted pixels and what they should become
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         rgb_expect_q.push_back(predict_rgb(req_data));
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rgb_expect_q.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            $display("%0t: unexpected beat, expected none, actual %h/%h/%h", $time,
                     rsp_data.red, rsp_data.green, rsp_data.blue);
         end else begin
            want = rgb_expect_q.pop_front();
            if (rsp_data.red !== want.red || rsp_data.green !== want.green ||
                rsp_data.blue !== want.blue) begin
               mismatch_count <= mismatch_count + 1;
               $display("%0t: rgb mismatch, expected %h/%h/%h, actual %h/%h/%h", $time,
                        want.red, want.green, want.blue,
                        rsp_data.red, rsp_data.green, rsp_data.blue);
            end
         end
      end
   end

   initial begin
      logic [LEVEL_BITS-1:0] levels[DIRECTED_LEVELS];
      levels = '{'0, 17'd1, 17'd65535, ONE_FX, 17'd65537, 17'd131071};

      // Extremes of saturation and value against the first hue
      foreach (levels[i]) queue_pixel('0, levels[i], levels[DIRECTED_LEVELS - 1 - i]);
      // Zero saturation at full value, full saturation and value at the top hue
      queue_pixel(16'd65535, '0, ONE_FX);
      queue_pixel(16'd65535, ONE_FX, ONE_FX);
      // Either side of each sector boundary
      queue_pixel(16'd10922, ONE_FX, ONE_FX);
      queue_pixel(16'd10923, ONE_FX, ONE_FX);
      queue_pixel(16'd21845, 17'd131071, 17'd131071);
      queue_pixel(16'd21846, 17'd65535, 17'd65535);
      queue_pixel(16'd32767, 17'd32768, ONE_FX);
      queue_pixel(16'd32768, 17'd32768, ONE_FX);
      queue_pixel(16'd43690, ONE_FX, 17'd40000);
      queue_pixel(16'd43691, ONE_FX, 17'd40000);
      queue_pixel(16'd54613, 17'd1, ONE_FX);
      queue_pixel(16'd54614, 17'd99999, 17'd1);
      queue_pixel(16'd60000, 17'd70000, 17'd50000);
      queue_pixel(16'd5000, 17'd20000, 17'd131071);
      queue_pixel(16'hAAAA, 17'h15555, 17'h0AAAA);
      queue_pixel(16'h5555, 17'h0AAAA, 17'h15555);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Hold the sender off until the directed beats are all back
      drain_pipeline();

      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         if (n == RANDOM_PIXELS / 2) drain_pipeline();
         queue_pixel(random_hue(), random_level(), random_level());
      end

      drain_pipeline();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && rgb_expect_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_to_channel.sv
rtl/hsv_to_rgb_convert.sv
rtl/hsvrgb_checker.sv
dv/tb_hsv_to_rgb_convert.sv
